FILE: rtl/cfc_pkg.sv
// Package for the CRC-32 length-prefixed frame checker.
// Holds status codes, the result record, frame constants and the CRC byte update.
// No dependencies.
`default_nettype none

package cfc_pkg;

  localparam int unsigned HeaderBytes  = 8;
  localparam int unsigned TrailerBytes = 4;
  localparam int unsigned MinFrame     = 12;
  localparam int unsigned CountWidth   = 17;

  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [31:0]           CrcPoly  = 32'hEDB8_8320;
  localparam logic [31:0]           CrcInit  = 32'hFFFF_FFFF;

  // identifier "RIP1" / "RIP2": first three characters shared
  localparam logic [7:0] IdChar0   = 8'h52;
  localparam logic [7:0] IdChar1   = 8'h49;
  localparam logic [7:0] IdChar2   = 8'h50;
  localparam logic [7:0] IdLastOne = 8'h31;
  localparam logic [7:0] IdLastTwo = 8'h32;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INCOMPLETE   = 3'd1,
    ST_BAD_IDENT    = 3'd2,
    ST_BAD_LENGTH   = 3'd3,
    ST_EXTRA_DATA   = 3'd4,
    ST_CRC_MISMATCH = 3'd5
  } status_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic       version;
    status_t    status_code;
    logic       frame_sound;
  } result_t;

  // expected identifier character at a header position
  function automatic logic [7:0] ident_char(input logic [1:0] pos, input logic two);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = IdChar0;
      2'd1:    ch = IdChar1;
      2'd2:    ch = IdChar2;
      default: ch = two ? IdLastTwo : IdLastOne;
    endcase
    return ch;
  endfunction

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfc_skid.sv
// Output register with one skid entry for the frame checker results.
// Depends on cfc_pkg (result_t).
`default_nettype none

module cfc_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  input  cfc_pkg::result_t      res,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cfc_pkg::result_t      out_res
);
  import cfc_pkg::*;

  logic    skid_valid;
  result_t skid_res;

  // skid occupied means upstream must hold
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        out_res   <= res;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_res   <= res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crc32_length_frame_checker.sv
// Top level of the CRC-32 length-prefixed frame checker.
// Depends on cfc_pkg and cfc_skid.
// Checker cfc_checker is bound to it from its own file.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  input     | in_valid / in_stall    | data_byte, end_of_datagram
//  output    | out_valid / out_stall  | is_status, payload_byte, version,
//            |                        | status_code, frame_sound
//  config    | cfg_valid / cfg_ready  | max_frame_bytes
//
// One byte per cycle unless stalled: each byte updates the frame state in one pass
// and its result (if any) enters the output register or skid entry the same edge.
// rst (synchronous, active high) clears frame state, output and skid entry;
// the length limit returns to 65507.
// in_stall rises only while the skid entry holds a result, i.e. after the
// output has been stalled with a result pending and another one arrived.
// cfg_ready is always high; the limit takes effect on the next check.
`default_nettype none

module crc32_length_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_datagram,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_status,
  output logic [7:0]       payload_byte,
  output logic             version,
  output logic [2:0]       status_code,
  output logic             frame_sound,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] max_frame_bytes
);
  import cfc_pkg::*;

  // configuration register
  logic [15:0] frame_limit;

  // frame state
  logic [CountWidth-1:0] byte_count;
  logic                  match_one;
  logic                  match_two;
  logic [31:0]           declared_length;
  logic [31:0]           crc;
  logic [31:0]           window;   // last four bytes, oldest in [7:0]

  logic [CountWidth-1:0] byte_count_next;
  logic                  match_one_next;
  logic                  match_two_next;
  logic [31:0]           declared_length_next;
  logic [31:0]           crc_next;
  logic [31:0]           window_next;

  logic    in_accept;
  logic    skid_full;
  logic    in_header;
  logic    in_body;
  logic    ident_ok;
  logic    len_ok;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= 16'd65507;
    end else if (cfg_valid && cfg_ready) begin
      frame_limit <= max_frame_bytes;
    end
  end

  // per-byte frame update
  always_comb begin
    byte_count_next = (byte_count == CountMax) ? byte_count : byte_count + 1'b1;

    match_one_next       = match_one;
    match_two_next       = match_two;
    declared_length_next = declared_length;
    in_header            = byte_count < CountWidth'(HeaderBytes);

    if (byte_count < CountWidth'(4)) begin
      if (data_byte != ident_char(byte_count[1:0], 1'b0)) match_one_next = 1'b0;
      if (data_byte != ident_char(byte_count[1:0], 1'b1)) match_two_next = 1'b0;
    end else if (in_header) begin
      // little-endian length, one byte lane per header position
      declared_length_next[{byte_count[1:0], 3'b000} +: 8] =
        declared_length[{byte_count[1:0], 3'b000} +: 8] | data_byte;
    end

    // bytes before the trailer start
    in_body = ({16'd0, byte_count} + 33'(TrailerBytes)) < {1'b0, declared_length_next};

    crc_next    = (in_header || in_body) ? crc_byte(crc, data_byte) : crc;
    window_next = {data_byte, window[31:8]};

    ident_ok = match_one_next || match_two_next;
    len_ok   = (declared_length_next >= 32'(MinFrame)) &&
               (declared_length_next <= {16'd0, frame_limit});
  end

  // result selection
  always_comb begin
    res           = '0;
    res.status_code = ST_OK;
    res_valid     = 1'b0;
    if (end_of_datagram) begin
      res_valid     = in_accept;
      res.is_status = 1'b1;
      if (byte_count_next < CountWidth'(HeaderBytes)) begin
        res.status_code = ST_INCOMPLETE;
      end else if (!ident_ok) begin
        res.status_code = ST_BAD_IDENT;
      end else begin
        res.version = match_two_next;
        if (!len_ok) begin
          res.status_code = ST_BAD_LENGTH;
        end else if (declared_length_next > {15'd0, byte_count_next}) begin
          res.status_code = ST_INCOMPLETE;
        end else if (declared_length_next < {15'd0, byte_count_next}) begin
          res.status_code = ST_EXTRA_DATA;
        end else begin
          res.status_code = ((crc_next ^ CrcInit) == window_next) ? ST_OK
                                                                 : ST_CRC_MISMATCH;
          res.frame_sound = 1'b1;
        end
      end
    end else if (!in_header && in_body && ident_ok && len_ok) begin
      res_valid        = in_accept;
      res.payload_byte = data_byte;
      res.version      = match_two_next;
    end
  end

  // frame state registers; the flagged byte returns them to reset
  always_ff @(posedge clk) begin
    if (rst || (in_accept && end_of_datagram)) begin
      byte_count      <= '0;
      match_one       <= 1'b1;
      match_two       <= 1'b1;
      declared_length <= '0;
      crc             <= CrcInit;
      window          <= '0;
    end else if (in_accept) begin
      byte_count      <= byte_count_next;
      match_one       <= match_one_next;
      match_two       <= match_two_next;
      declared_length <= declared_length_next;
      crc             <= crc_next;
      window          <= window_next;
    end
  end

  cfc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign is_status    = out_res.is_status;
  assign payload_byte = out_res.payload_byte;
  assign version      = out_res.version;
  assign status_code  = out_res.status_code;
  assign frame_sound  = out_res.frame_sound;

endmodule

`default_nettype wire

FILE: rtl/cfc_checker.sv
// Port-level assertions for the frame checker, bound to the top level.
// Depends on cfc_pkg (status codes) and crc32_length_frame_checker.
`default_nettype none

module cfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        is_status,
  input wire logic [7:0]  payload_byte,
  input wire logic        version,
  input wire logic [2:0]  status_code,
  input wire logic        frame_sound
);
  import cfc_pkg::*;

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // payload transactions carry no status information
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> status_code == ST_OK && !frame_sound)
    else $error("payload result carries status");

  // sound framing only with ok or crc mismatch on a status
  a_intact: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_sound |->
      is_status && payload_byte == 8'd0 &&
      (status_code == ST_OK || status_code == ST_CRC_MISMATCH))
    else $error("frame_sound on wrong status");

  // a bad identifier has no version
  a_bad_ident_ver: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status && status_code == ST_BAD_IDENT |-> !version)
    else $error("version set on bad identifier");

endmodule

bind crc32_length_frame_checker cfc_checker u_cfc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .is_status    (is_status),
  .payload_byte (payload_byte),
  .version      (version),
  .status_code  (status_code),
  .frame_sound  (frame_sound)
);

`default_nettype wire
